// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Simulation builds get concurrent assertions. Synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SRTF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srtf: property violated");
// Condition must never be seen at a clock edge outside reset.
`define SRTF_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("srtf: forbidden condition seen");
`else
`define SRTF_ASSERT(lbl, clk, rst_n, prop)
`define SRTF_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/srtf_pkg.sv =====
`timescale 1ns / 1ps
package srtf_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS     = 20;
    localparam int ID_W          = 8;
    localparam int ARR_W         = 16;
    localparam int LEN_W         = 12;

    // request opcodes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic             action;
        logic [ID_W-1:0]  proc_id;
        logic [ARR_W-1:0] arrive_at;
        logic [LEN_W-1:0] run_length;
    } t_request;

    typedef struct packed {
        logic                 load_accepted;
        logic [TIME_BITS-1:0] slot_time;
        logic [ID_W-1:0]      running_id;
        logic                 finished;
        logic [TIME_BITS-1:0] done_at;
        logic [TIME_BITS-1:0] turnaround;
        logic [TIME_BITS-1:0] wait_total;
        logic [TIME_BITS-1:0] first_run_delay;
        logic                 all_done;
    } t_result;

    // one process table entry, one RAM word
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [ARR_W-1:0]     arrival;
        logic [LEN_W-1:0]     length;
        logic [LEN_W-1:0]     left;
        logic                 begun;
        logic [TIME_BITS-1:0] first_delay;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIRST,
        S_TURN,
        S_WAIT,
        S_REPORT
    } t_state;

endpackage

// ===== rtl/core/srtf_ram.sv =====
`timescale 1ns / 1ps
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/srtf_alu.sv =====
`timescale 1ns / 1ps
// Shared time subtractor: diff = a - b, borrow set when b > a.
module srtf_alu (
    input  logic [srtf_pkg::TIME_BITS-1:0] i_a,
    input  logic [srtf_pkg::TIME_BITS-1:0] i_b,
    output logic [srtf_pkg::TIME_BITS-1:0] o_diff,
    output logic                           o_borrow
);
    import srtf_pkg::*;

    logic [TIME_BITS:0] sub;

    assign sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = sub[TIME_BITS-1:0];
    assign o_borrow = sub[TIME_BITS];

endmodule

// ===== rtl/core/srtf_preemptive_scheduler.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Preemptive shortest-remaining-time-first scheduler.
// Request channel: start with i_req, taken on a rising edge where start is high
// and busy is low. i_req.action selects a load (store one process) or a tick
// (run the best ready process for one time unit and advance time).
// Result channel: o_res is valid for exactly one cycle while o_valid is high.
// Every request yields exactly one result. The receiver cannot stall the block.
// Load: the result strobes in the cycle after the accepting edge, busy never
// rises, and the next request can be taken right away.
// Tick: the table is walked through one RAM read port, one slot per cycle,
// with a single compare stage tracking the minimum remaining time. After the
// walk, one shared subtractor forms first-run delay, turnaround and wait in
// three steps, skipped when no process is ready. The result strobes as busy
// falls, and the next request is taken in that cycle.
// Reset (synchronous, active low) empties the table and zeroes time and the
// counters. Table RAM is not cleared: only slots below the load count are read.
// Time saturates at its all-ones value.
module srtf_preemptive_scheduler #(
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  srtf_pkg::t_request i_req,
    output logic               busy,
    output logic               o_valid,
    output srtf_pkg::t_result  o_res
);
    import srtf_pkg::*;

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // control state
    t_state               r_state,    n_state;
    logic [TIME_BITS-1:0] r_now,      n_now;
    logic [CW-1:0]        r_loaded,   n_loaded;
    logic [CW-1:0]        r_finished, n_finished;
    logic                 r_rd_vld,   n_rd_vld;
    logic                 r_found,    n_found;
    logic                 r_valid,    n_valid;

    // payload / working registers
    logic [TIME_BITS-1:0] r_tick_time, n_tick_time;
    logic [CW-1:0]        r_idx,       n_idx;
    logic [IW-1:0]        r_rd_idx,    n_rd_idx;
    logic [IW-1:0]        r_best_idx,  n_best_idx;
    t_slot                r_best,      n_best;
    logic [TIME_BITS-1:0] r_turn,      n_turn;
    logic [TIME_BITS-1:0] r_wait,      n_wait;
    t_result              r_res,       n_res;

    // table RAM port
    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    t_slot                   ram_wdata;
    logic [IW-1:0]           ram_raddr;
    logic [$bits(t_slot)-1:0] ram_rdata;
    t_slot                   rd_slot;

    // shared subtractor
    logic [TIME_BITS-1:0] alu_a, alu_b, alu_diff;
    logic                 alu_borrow;

    logic                 load_ok;
    logic                 elig;
    logic                 more;
    logic                 fin;
    logic [TIME_BITS-1:0] now_inc;
    logic [CW-1:0]        loaded_inc;

    srtf_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (MAX_PROCS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    srtf_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_diff   (alu_diff),
        .o_borrow (alu_borrow)
    );

    assign rd_slot    = ram_rdata;
    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    // slot is a candidate if it has arrived and still has work left
    assign elig       = (TIME_BITS'(rd_slot.arrival) <= r_now) && (rd_slot.left != '0);
    assign more       = (r_idx < r_loaded);
    assign now_inc    = (r_now == TIME_MAX) ? r_now : r_now + TIME_BITS'(1);
    assign loaded_inc = r_loaded + CW'(1);
    assign load_ok    = (r_loaded < CW'(MAX_PROCS)) && (i_req.proc_id != '0)
                        && (i_req.run_length != '0);
    // chosen process hits zero left after this unit
    assign fin        = r_found && (r_best.left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_loaded   <= '0;
            r_finished <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_now      <= n_now;
            r_loaded   <= n_loaded;
            r_finished <= n_finished;
            r_rd_vld   <= n_rd_vld;
            r_found    <= n_found;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick_time <= n_tick_time;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_best_idx  <= n_best_idx;
        r_best      <= n_best;
        r_turn      <= n_turn;
        r_wait      <= n_wait;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_loaded    = r_loaded;
        n_finished  = r_finished;
        n_rd_vld    = r_rd_vld;
        n_found     = r_found;
        n_valid     = 1'b0;
        n_tick_time = r_tick_time;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_turn      = r_turn;
        n_wait      = r_wait;
        n_res       = r_res;

        ram_we      = 1'b0;
        ram_waddr   = r_best_idx;
        ram_wdata   = r_best;
        ram_raddr   = r_idx[IW-1:0];

        alu_a       = r_now;
        alu_b       = TIME_BITS'(r_best.arrival);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.action == ACT_LOAD) begin
                        if (load_ok) begin
                            ram_we                = 1'b1;
                            ram_waddr             = r_loaded[IW-1:0];
                            ram_wdata.id          = i_req.proc_id;
                            ram_wdata.arrival     = i_req.arrive_at;
                            ram_wdata.length      = i_req.run_length;
                            ram_wdata.left        = i_req.run_length;
                            ram_wdata.begun       = 1'b0;
                            ram_wdata.first_delay = '0;
                            n_loaded              = loaded_inc;
                        end
                        n_valid             = 1'b1;
                        n_res               = '0;
                        n_res.load_accepted = load_ok;
                        n_res.all_done      = load_ok ? (r_finished == loaded_inc)
                                                      : (r_finished == r_loaded);
                    end else begin
                        n_state     = S_SCAN;
                        n_idx       = '0;
                        n_rd_vld    = 1'b0;
                        n_found     = 1'b0;
                        n_tick_time = r_now;
                    end
                end
            end

            S_SCAN: begin
                // issue one read per cycle, compare the word read last cycle
                if (more) begin
                    n_idx    = r_idx + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IW-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                end
                // strict less-than keeps the lowest slot on a tie
                if (r_rd_vld && elig && (!r_found || (rd_slot.left < r_best.left))) begin
                    n_found    = 1'b1;
                    n_best     = rd_slot;
                    n_best_idx = r_rd_idx;
                end
                if (!more && !r_rd_vld) begin
                    n_now   = now_inc;
                    n_state = r_found ? S_FIRST : S_REPORT;
                end
            end

            S_FIRST: begin
                alu_a = r_tick_time;
                if (!r_best.begun) begin
                    n_best.first_delay = alu_diff;
                    n_best.begun       = 1'b1;
                end
                n_best.left = r_best.left - LEN_W'(1);
                n_state     = S_TURN;
            end

            S_TURN: begin
                // r_now already holds the advanced time
                n_turn  = alu_diff;
                n_state = S_WAIT;
            end

            S_WAIT: begin
                alu_a   = r_turn;
                alu_b   = TIME_BITS'(r_best.length);
                n_wait  = alu_borrow ? '0 : alu_diff;
                n_state = S_REPORT;
            end

            S_REPORT: begin
                ram_we                = r_found;
                n_finished            = r_finished + CW'(fin);
                n_valid               = 1'b1;
                n_res                 = '0;
                n_res.slot_time       = r_tick_time;
                n_res.running_id      = r_found ? r_best.id : '0;
                n_res.finished        = fin;
                n_res.done_at         = fin ? r_now : '0;
                n_res.turnaround      = fin ? r_turn : '0;
                n_res.wait_total      = fin ? r_wait : '0;
                n_res.first_run_delay = fin ? r_best.first_delay : '0;
                n_res.all_done        = ((r_finished + CW'(fin)) == r_loaded);
                n_state               = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // completions can never outrun loads, and the table never overfills
    `SRTF_ASSERT(a_count_order, i_clk, i_rst_n, (r_finished <= r_loaded) && (r_loaded <= CW'(MAX_PROCS)))
    // a load request's result strobes in the next cycle and leaves the block free
    `SRTF_ASSERT(a_load_one_cycle, i_clk, i_rst_n, (start && !busy && i_req.action == ACT_LOAD) |=> (o_valid && !busy))
    // a tick request occupies the sequencer
    `SRTF_ASSERT(a_tick_busy, i_clk, i_rst_n, (start && !busy && i_req.action == ACT_TICK) |=> (busy && !o_valid))
    // results are only produced on the way back to idle
    `SRTF_NEVER(a_valid_while_busy, i_clk, i_rst_n, o_valid && busy)
    // a completion names a real process and its wait fits inside its turnaround
    `SRTF_ASSERT(a_finish_sane, i_clk, i_rst_n, (o_valid && o_res.finished) |-> ((o_res.running_id != '0) && (o_res.wait_total <= o_res.turnaround)))

endmodule
